// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  // Replacement character for an invalid or cut-short sequence.
  localparam logic [20:0] REPL_CHAR = 21'h00FFFD;

  // Lead byte patterns and masks.
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] MASK_TWO    = 8'hE0;
  localparam logic [7:0] LEAD_TWO    = 8'hC0;
  localparam logic [7:0] MASK_THREE  = 8'hF0;
  localparam logic [7:0] LEAD_THREE  = 8'hE0;
  localparam logic [7:0] MASK_FOUR   = 8'hF8;
  localparam logic [7:0] LEAD_FOUR   = 8'hF0;

  // One unit of work for the back end: up to four bytes, lead byte first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      have;
    logic            at_end;
  } job_t;

  // Sequence length announced by a lead byte; zero marks an invalid lead.
  function automatic logic [2:0] lead_length(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c < ASCII_LIMIT) begin
      len = 3'd1;
    end else if ((c & MASK_TWO) == LEAD_TWO) begin
      len = 3'd2;
    end else if ((c & MASK_THREE) == LEAD_THREE) begin
      len = 3'd3;
    end else if ((c & MASK_FOUR) == LEAD_FOUR) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Builds a code point from a window of bytes starting at the lead byte.
  function automatic logic [20:0] assemble(input logic [3:0][7:0] w, input logic [2:0] len);
    logic [20:0] cp;
    case (len)
      3'd1:    cp = {13'd0, w[0]};
      3'd2:    cp = {10'd0, w[0][4:0], w[1][5:0]};
      3'd3:    cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
      default: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
    endcase
    return cp;
  endfunction

endpackage

// ===== sv/utf8d_if.sv =====
// Byte channel: one raw text byte per request.
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source(output valid, output data_byte, output end_of_string, input ready);
  modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

// Code point channel: one decoded character per request.
interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        last_of_run;
  logic        text_done;

  modport source(output valid, output code_point, output last_of_run, output text_done,
                 input ready);
  modport sink(input valid, input code_point, input last_of_run, input text_done,
               output ready);
endinterface

// ===== sv/utf8_byte_stream_decoder_top.sv =====
// Channel     Modport  Payload                                   Request moves
// byte_chan   sink     data_byte[7:0], end_of_string             one text byte
// cp_chan     source   code_point[20:0], last_of_run, text_done  one code point
//
// Bytes are taken one per cycle while the request queue has room.
// The back end gives one code point per cycle unless stalled; one decode step sets the rate.
// A final byte that cuts a sequence short gives up to three code points.
// Reset is synchronous and clears the pending count, queue pointers and fill, decode position and output valid.
// Each side stalls on its own; the queue and the output register absorb the difference.
module utf8_byte_stream_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  utf8d_byte_if.sink   byte_chan,
  utf8d_cp_if.source   cp_chan
);
  import utf8d_pkg::*;

  logic full;
  logic push;
  job_t job;
  logic head_valid;
  job_t head_job;
  logic pop;

  utf8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .full      (full),
    .push      (push),
    .job       (job)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .full       (full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  utf8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .cp_chan    (cp_chan)
  );

endmodule

// ===== sv/utf8d_front.sv =====
module utf8d_front (
  input  logic            clk,
  input  logic            rst,
  utf8d_byte_if.sink      byte_chan,
  input  logic            full,
  output logic            push,
  output utf8d_pkg::job_t job
);
  import utf8d_pkg::*;

  logic [2:0][7:0] pending;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            accept;
  logic [2:0]      have;
  logic [2:0]      len_new;
  logic [2:0]      len_lead;
  logic            emit;

  assign byte_chan.ready = !full;
  assign accept = byte_chan.valid && byte_chan.ready;

  // Decide whether the waiting bytes plus this one form work for the back end.
  always_comb begin
    have     = {1'b0, count} + 3'd1;
    len_new  = lead_length(byte_chan.data_byte);
    len_lead = lead_length(pending[0]);
    if (byte_chan.end_of_string) begin
      emit = 1'b1;
    end else if (count == 2'd0) begin
      emit = (len_new <= 3'd1);
    end else begin
      emit = (have == len_lead);
    end
  end

  // The new byte takes the slot after the waiting ones.
  always_comb begin
    job.bytes[0] = (count == 2'd0) ? byte_chan.data_byte : pending[0];
    job.bytes[1] = (count == 2'd1) ? byte_chan.data_byte : pending[1];
    job.bytes[2] = (count == 2'd2) ? byte_chan.data_byte : pending[2];
    job.bytes[3] = byte_chan.data_byte;
    job.have     = have;
    job.at_end   = byte_chan.end_of_string;
  end

  assign push = accept && emit;

  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = emit ? 2'd0 : count + 2'd1;
    end
  end

  // Pending count is control state; the byte store needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !emit) begin
      pending[count] <= byte_chan.data_byte;
    end
  end

  // The buffer is always empty after the final byte of a text.
  a_empty_after_end: assert property (@(posedge clk) disable iff (rst)
    accept && byte_chan.end_of_string |=> count == 2'd0)
    else $error("pending bytes left after end of text");

  // A byte is only stored while its sequence is still short of its length.
  a_store_short: assert property (@(posedge clk) disable iff (rst)
    accept && !emit && count != 2'd0 |-> have < len_lead)
    else $error("stored byte beyond sequence length");

endmodule

// ===== sv/utf8d_queue.sv =====
module utf8d_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utf8d_pkg::job_t push_job,
  output logic            full,
  output logic            head_valid,
  output utf8d_pkg::job_t head_job,
  input  logic            pop
);
  import utf8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !head_valid |-> !pop)
    else $error("request popped from an empty queue");

endmodule

// ===== sv/utf8d_back.sv =====
module utf8d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  utf8d_pkg::job_t head_job,
  output logic            pop,
  utf8d_cp_if.source      cp_chan
);
  import utf8d_pkg::*;

  logic [1:0]      pos;
  logic [1:0]      pos_next;
  logic [3:0][7:0] window;
  logic [1:0]      idx;
  logic [2:0]      len;
  logic [2:0]      rem;
  logic [2:0]      adv;
  logic [2:0]      pos_sum;
  logic [20:0]     cp;
  logic            last;
  logic            step;
  logic            out_valid;
  logic            out_valid_next;

  // Bytes seen from the current position onwards.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      idx       = pos + 2'(k);
      window[k] = head_job.bytes[idx];
    end
  end

  // One decode step: a whole sequence or a single replaced byte.
  always_comb begin
    len = lead_length(window[0]);
    rem = head_job.have - {1'b0, pos};
    if (len != 3'd0 && rem >= len) begin
      cp  = assemble(window, len);
      adv = len;
    end else begin
      cp  = REPL_CHAR;
      adv = 3'd1;
    end
    pos_sum = {1'b0, pos} + adv;
    last    = (pos_sum >= head_job.have);
  end

  assign step = head_valid && (!out_valid || cp_chan.ready);
  assign pop  = step && last;

  always_comb begin
    pos_next = pos;
    if (step) begin
      pos_next = last ? 2'd0 : pos_sum[1:0];
    end
    out_valid_next = out_valid;
    if (step) begin
      out_valid_next = 1'b1;
    end else if (cp_chan.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      pos       <= pos_next;
      out_valid <= out_valid_next;
    end
  end

  // Output register; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      cp_chan.code_point  <= cp;
      cp_chan.last_of_run <= last;
      cp_chan.text_done   <= last && head_job.at_end;
    end
  end

  assign cp_chan.valid = out_valid;

  // The position always points inside the bytes of the queue head.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> {1'b0, pos} < head_job.have)
    else $error("decode position beyond request bytes");

endmodule
